// File: hw/rtl/frc_pkg.sv
`default_nettype none

package frc_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned FragBytesDefault   = 4096;
  localparam int unsigned HeaderBytesDefault = 48;
  localparam int unsigned QueueDepthDefault  = 2;

  // Fixed field widths
  localparam int unsigned ByteLenW = 13;
  localparam int unsigned SeqW     = 64;
  localparam int unsigned LenW     = 32;
  localparam int unsigned PortW    = 16;
  localparam int unsigned FlagW    = 8;
  localparam int unsigned CreditW  = 8;
  localparam int unsigned OutcomeW = 4;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;

  // Register reset values
  localparam logic [FlagW-1:0] CongFlagReset = 8'd8;
  localparam logic [FlagW-1:0] AckMaskReset  = 8'd2;

  // Register indexes (paddr[2])
  localparam logic RegCongFlag = 1'b0;
  localparam logic RegAckMask  = 1'b1;

  typedef enum logic [OutcomeW-1:0] {
    OC_INACTIVE = 4'd0,
    OC_ERROR    = 4'd1,
    OC_SHORT    = 4'd2,
    OC_BADSUM   = 4'd3,
    OC_ACKONLY  = 4'd4,
    OC_FRAG     = 4'd5,
    OC_DONE     = 4'd6,
    OC_CONGMAP  = 4'd7,
    OC_MISMATCH = 4'd8
  } outcome_e;

  // Class the front end assigns to a request
  typedef enum logic [2:0] {
    CLS_INACTIVE,
    CLS_ERROR,
    CLS_SHORT,
    CLS_BADSUM,
    CLS_ACKONLY,
    CLS_DATA
  } class_e;

  typedef struct packed {
    class_e              cls;
    logic [SeqW-1:0]     sequence_no;
    logic [LenW-1:0]     length;
    logic [PortW-1:0]    src_port;
    logic [PortW-1:0]    dst_port;
    logic [FlagW-1:0]    flags;
    logic [SeqW-1:0]     ack_seq;
    logic [CreditW-1:0]  credit;
  } entry_t;

  typedef struct packed {
    outcome_e            outcome;
    logic                drop_connection;
    logic                peer_ack_valid;
    logic [SeqW-1:0]     peer_ack;
    logic [CreditW-1:0]  credit_add;
    logic                next_ack_valid;
    logic [SeqW-1:0]     next_ack;
    logic                ack_urgent;
  } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/frc_front.sv
`default_nettype none

module frc_front #(
  parameter int unsigned HEADER_BYTES = frc_pkg::HeaderBytesDefault
) (
  input  wire logic                              conn_active_i,
  input  wire logic                              completion_ok_i,
  input  wire logic [frc_pkg::ByteLenW-1:0]      xfer_bytes_i,
  input  wire logic                              checksum_ok_i,
  input  wire logic [frc_pkg::SeqW-1:0]          hdr_sequence_i,
  input  wire logic [frc_pkg::LenW-1:0]          hdr_length_i,
  input  wire logic [frc_pkg::PortW-1:0]         hdr_src_port_i,
  input  wire logic [frc_pkg::PortW-1:0]         hdr_dst_port_i,
  input  wire logic [frc_pkg::FlagW-1:0]         hdr_flag_bits_i,
  input  wire logic [frc_pkg::SeqW-1:0]          hdr_ack_seq_i,
  input  wire logic [frc_pkg::CreditW-1:0]       hdr_credit_i,
  output frc_pkg::entry_t                        entry_o
);

  logic [31:0] blen_ext;
  logic        is_short;
  logic        no_data;

  assign blen_ext = {{(32-frc_pkg::ByteLenW){1'b0}}, xfer_bytes_i};
  assign is_short = blen_ext < 32'(HEADER_BYTES);
  assign no_data  = blen_ext == 32'(HEADER_BYTES);

  always_comb begin
    entry_o.sequence_no = hdr_sequence_i;
    entry_o.length      = hdr_length_i;
    entry_o.src_port    = hdr_src_port_i;
    entry_o.dst_port    = hdr_dst_port_i;
    entry_o.flags       = hdr_flag_bits_i;
    entry_o.ack_seq     = hdr_ack_seq_i;
    entry_o.credit      = hdr_credit_i;
    // Checks in priority order
    if (!conn_active_i) begin
      entry_o.cls = frc_pkg::CLS_INACTIVE;
    end else if (!completion_ok_i) begin
      entry_o.cls = frc_pkg::CLS_ERROR;
    end else if (is_short) begin
      entry_o.cls = frc_pkg::CLS_SHORT;
    end else if (!checksum_ok_i) begin
      entry_o.cls = frc_pkg::CLS_BADSUM;
    end else if (hdr_src_port_i == '0 && hdr_dst_port_i == '0 && no_data) begin
      entry_o.cls = frc_pkg::CLS_ACKONLY;
    end else begin
      entry_o.cls = frc_pkg::CLS_DATA;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/frc_queue.sv
`default_nettype none

module frc_queue #(
  parameter int unsigned QUEUE_DEPTH = frc_pkg::QueueDepthDefault
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire frc_pkg::entry_t push_entry_i,
  output logic                 full_o,
  output logic                 head_valid_o,
  output frc_pkg::entry_t      head_entry_o,
  input  wire logic            pop_i
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);

  frc_pkg::entry_t slots_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign full_o       = count_q == CntW'(QUEUE_DEPTH);
  assign head_valid_o = count_q != '0;
  assign head_entry_o = slots_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/frc_back.sv
`default_nettype none

module frc_back #(
  parameter int unsigned FRAG_BYTES = frc_pkg::FragBytesDefault
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [frc_pkg::FlagW-1:0]   cong_flag_i,
  input  wire logic [frc_pkg::FlagW-1:0]   ack_mask_i,
  input  wire logic                        head_valid_i,
  input  wire frc_pkg::entry_t             head_entry_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  output frc_pkg::result_t                 result_o,
  input  wire logic                        out_stall_i
);

  localparam logic [frc_pkg::LenW-1:0] FragLen = frc_pkg::LenW'(FRAG_BYTES);

  logic                          assembling_q, assembling_d;
  logic [frc_pkg::LenW-1:0]      remaining_q, remaining_d;
  logic [frc_pkg::SeqW-1:0]      held_seq_q, held_seq_d;
  logic [frc_pkg::LenW-1:0]      held_len_q, held_len_d;
  logic [frc_pkg::PortW-1:0]     held_src_q, held_src_d;
  logic [frc_pkg::PortW-1:0]     held_dst_q, held_dst_d;
  logic [frc_pkg::FlagW-1:0]     held_flags_q, held_flags_d;
  logic                          out_valid_q;
  frc_pkg::result_t              result_q, result_d;
  logic                          mismatch;

  // Take the next request whenever the output register is free or drains now
  assign pop_o       = head_valid_i && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

  assign mismatch = held_seq_q != head_entry_i.sequence_no ||
                    held_len_q != head_entry_i.length ||
                    held_src_q != head_entry_i.src_port ||
                    held_dst_q != head_entry_i.dst_port;

  always_comb begin
    assembling_d = assembling_q;
    remaining_d  = remaining_q;
    held_seq_d   = held_seq_q;
    held_len_d   = held_len_q;
    held_src_d   = held_src_q;
    held_dst_d   = held_dst_q;
    held_flags_d = held_flags_q;
    result_d     = '0;
    result_d.outcome = frc_pkg::OC_INACTIVE;
    case (head_entry_i.cls)
      frc_pkg::CLS_INACTIVE: begin
        result_d.outcome = frc_pkg::OC_INACTIVE;
      end
      frc_pkg::CLS_ERROR, frc_pkg::CLS_SHORT, frc_pkg::CLS_BADSUM: begin
        result_d.outcome = (head_entry_i.cls == frc_pkg::CLS_ERROR) ? frc_pkg::OC_ERROR :
                           (head_entry_i.cls == frc_pkg::CLS_SHORT) ? frc_pkg::OC_SHORT :
                                                                       frc_pkg::OC_BADSUM;
        result_d.drop_connection = 1'b1;
        assembling_d = 1'b0;
        remaining_d  = '0;
      end
      frc_pkg::CLS_ACKONLY: begin
        result_d.outcome        = frc_pkg::OC_ACKONLY;
        result_d.peer_ack_valid = 1'b1;
        result_d.peer_ack       = head_entry_i.ack_seq;
        result_d.credit_add     = head_entry_i.credit;
      end
      frc_pkg::CLS_DATA: begin
        result_d.peer_ack_valid = 1'b1;
        result_d.peer_ack       = head_entry_i.ack_seq;
        result_d.credit_add     = head_entry_i.credit;
        if (assembling_q && mismatch) begin
          result_d.outcome         = frc_pkg::OC_MISMATCH;
          result_d.drop_connection = 1'b1;
          assembling_d = 1'b0;
          remaining_d  = '0;
        end else begin
          // Latch the header on a first fragment
          if (!assembling_q) begin
            held_seq_d   = head_entry_i.sequence_no;
            held_len_d   = head_entry_i.length;
            held_src_d   = head_entry_i.src_port;
            held_dst_d   = head_entry_i.dst_port;
            held_flags_d = head_entry_i.flags;
            remaining_d  = head_entry_i.length;
          end
          if (remaining_d > FragLen) begin
            remaining_d      = remaining_d - FragLen;
            assembling_d     = 1'b1;
            result_d.outcome = frc_pkg::OC_FRAG;
          end else begin
            remaining_d  = '0;
            assembling_d = 1'b0;
            if (held_flags_d == cong_flag_i) begin
              result_d.outcome = frc_pkg::OC_CONGMAP;
            end else begin
              result_d.outcome        = frc_pkg::OC_DONE;
              result_d.next_ack_valid = 1'b1;
              result_d.next_ack       = held_seq_d;
            end
            result_d.ack_urgent = (held_flags_d & ack_mask_i) != '0;
          end
        end
      end
      default: begin
        result_d.outcome = frc_pkg::OC_INACTIVE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      assembling_q <= 1'b0;
      remaining_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (pop_o) begin
        assembling_q <= assembling_d;
        remaining_q  <= remaining_d;
        out_valid_q  <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      held_seq_q   <= held_seq_d;
      held_len_q   <= held_len_d;
      held_src_q   <= held_src_d;
      held_dst_q   <= held_dst_d;
      held_flags_q <= held_flags_d;
      result_q     <= result_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/fragment_reassembly_checker.sv
// Channel   Direction  Handshake               Payload
// in        request    in_valid_i / in_stall_o  one receive completion with parsed header
// out       result     out_valid_o/out_stall_i  outcome, ack, credit and completion fields
// cfg       APB        psel/penable/pready      cong flag value (0x0), ack mask (0x4)
//
// Flow: one request per cycle sustained while the output does not stall; a request is
// written into a queue slot when accepted and then into the output register, from
// which its result is taken.
// The back end's combinational header compare and remaining-count subtract set the rate.
// Reset: asynchronous, active low; clears reassembly, the queue and output valid.
// Stalls: the request queue absorbs output stalls; in_stall_o rises only when it fills.

`default_nettype none

module fragment_reassembly_checker #(
  parameter int unsigned FRAG_BYTES   = frc_pkg::FragBytesDefault,
  parameter int unsigned HEADER_BYTES = frc_pkg::HeaderBytesDefault,
  parameter int unsigned QUEUE_DEPTH  = frc_pkg::QueueDepthDefault
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,

  // Request channel
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic                              conn_active_i,
  input  wire logic                              completion_ok_i,
  input  wire logic [frc_pkg::ByteLenW-1:0]      xfer_bytes_i,
  input  wire logic                              checksum_ok_i,
  input  wire logic [frc_pkg::SeqW-1:0]          hdr_sequence_i,
  input  wire logic [frc_pkg::LenW-1:0]          hdr_length_i,
  input  wire logic [frc_pkg::PortW-1:0]         hdr_src_port_i,
  input  wire logic [frc_pkg::PortW-1:0]         hdr_dst_port_i,
  input  wire logic [frc_pkg::FlagW-1:0]         hdr_flag_bits_i,
  input  wire logic [frc_pkg::SeqW-1:0]          hdr_ack_seq_i,
  input  wire logic [frc_pkg::CreditW-1:0]       hdr_credit_i,

  // Result channel
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [frc_pkg::OutcomeW-1:0]           outcome_o,
  output logic                                   drop_connection_o,
  output logic                                   peer_ack_valid_o,
  output logic [frc_pkg::SeqW-1:0]               peer_ack_o,
  output logic [frc_pkg::CreditW-1:0]            credit_add_o,
  output logic                                   next_ack_valid_o,
  output logic [frc_pkg::SeqW-1:0]               next_ack_o,
  output logic                                   ack_urgent_o,

  // Configuration port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [frc_pkg::CfgAddrW-1:0]      paddr,
  input  wire logic [frc_pkg::CfgDataW-1:0]      pwdata,
  output logic [frc_pkg::CfgDataW-1:0]           prdata,
  output logic                                   pready
);

  frc_pkg::entry_t        front_entry;
  frc_pkg::entry_t        head_entry;
  frc_pkg::result_t       result;
  logic                   queue_full;
  logic                   head_valid;
  logic                   pop;
  logic [frc_pkg::FlagW-1:0] cong_flag_q;
  logic [frc_pkg::FlagW-1:0] ack_mask_q;
  logic                   cfg_write;

  // Configuration registers: the user must write them only while the datapath is idle; the block does not enforce this
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cong_flag_q <= frc_pkg::CongFlagReset;
      ack_mask_q  <= frc_pkg::AckMaskReset;
    end else if (cfg_write) begin
      case (paddr[2])
        frc_pkg::RegCongFlag: cong_flag_q <= pwdata[frc_pkg::FlagW-1:0];
        frc_pkg::RegAckMask:  ack_mask_q  <= pwdata[frc_pkg::FlagW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      frc_pkg::RegCongFlag: prdata = {{(frc_pkg::CfgDataW-frc_pkg::FlagW){1'b0}}, cong_flag_q};
      frc_pkg::RegAckMask:  prdata = {{(frc_pkg::CfgDataW-frc_pkg::FlagW){1'b0}}, ack_mask_q};
      default:              prdata = '0;
    endcase
  end

  // Front end: classify the completion against connection state, status, length, checksum and ports
  frc_front #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_front (
    .conn_active_i   (conn_active_i),
    .completion_ok_i (completion_ok_i),
    .xfer_bytes_i    (xfer_bytes_i),
    .checksum_ok_i   (checksum_ok_i),
    .hdr_sequence_i  (hdr_sequence_i),
    .hdr_length_i    (hdr_length_i),
    .hdr_src_port_i  (hdr_src_port_i),
    .hdr_dst_port_i  (hdr_dst_port_i),
    .hdr_flag_bits_i (hdr_flag_bits_i),
    .hdr_ack_seq_i   (hdr_ack_seq_i),
    .hdr_credit_i    (hdr_credit_i),
    .entry_o         (front_entry)
  );

  // Hold classified requests so input and output stall independently
  frc_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (in_valid_i),
    .push_entry_i (front_entry),
    .full_o       (queue_full),
    .head_valid_o (head_valid),
    .head_entry_o (head_entry),
    .pop_i        (pop)
  );

  assign in_stall_o = queue_full;

  // Back end: advance reassembly state and register one result per request
  frc_back #(
    .FRAG_BYTES (FRAG_BYTES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cong_flag_i  (cong_flag_q),
    .ack_mask_i   (ack_mask_q),
    .head_valid_i (head_valid),
    .head_entry_i (head_entry),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .result_o     (result),
    .out_stall_i  (out_stall_i)
  );

  assign outcome_o         = result.outcome;
  assign drop_connection_o = result.drop_connection;
  assign peer_ack_valid_o  = result.peer_ack_valid;
  assign peer_ack_o        = result.peer_ack;
  assign credit_add_o      = result.credit_add;
  assign next_ack_valid_o  = result.next_ack_valid;
  assign next_ack_o        = result.next_ack;
  assign ack_urgent_o      = result.ack_urgent;

endmodule

`default_nettype wire

// File: hw/rtl/frc_checker.sv
`default_nettype none

module frc_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire logic [frc_pkg::OutcomeW-1:0]  outcome_o,
  input wire logic                          drop_connection_o,
  input wire logic                          peer_ack_valid_o,
  input wire logic [frc_pkg::SeqW-1:0]      peer_ack_o,
  input wire logic [frc_pkg::CreditW-1:0]   credit_add_o,
  input wire logic                          next_ack_valid_o
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(outcome_o))
    else $error("stalled result changed");

  // Drop only for the error, short, bad checksum and mismatch outcomes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && drop_connection_o |->
      outcome_o == frc_pkg::OC_ERROR || outcome_o == frc_pkg::OC_SHORT ||
      outcome_o == frc_pkg::OC_BADSUM || outcome_o == frc_pkg::OC_MISMATCH)
    else $error("drop with wrong outcome");

  // Next ack only on a completed data message
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && next_ack_valid_o |-> outcome_o == frc_pkg::OC_DONE &&
      peer_ack_valid_o && !drop_connection_o)
    else $error("next ack without completed message");

  // No ack and no credit without a verified header
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !peer_ack_valid_o |-> peer_ack_o == '0 && credit_add_o == '0)
    else $error("ack or credit without verified header");

endmodule

bind fragment_reassembly_checker frc_checker u_frc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .outcome_o         (outcome_o),
  .drop_connection_o (drop_connection_o),
  .peer_ack_valid_o  (peer_ack_valid_o),
  .peer_ack_o        (peer_ack_o),
  .credit_add_o      (credit_add_o),
  .next_ack_valid_o  (next_ack_valid_o)
);

`default_nettype wire

// File: verif/tb_fragment_reassembly_checker.sv
`timescale 1ns / 1ps

module tb_fragment_reassembly_checker;

  localparam int unsigned FragSize    = frc_pkg::FragBytesDefault;
  localparam int unsigned HdrSize     = frc_pkg::HeaderBytesDefault;
  localparam int unsigned MaxByteLen  = FragSize + HdrSize;
  localparam logic [frc_pkg::ByteLenW-1:0] HdrLen  =
    frc_pkg::ByteLenW'(frc_pkg::HeaderBytesDefault);
  localparam logic [frc_pkg::LenW-1:0]     FragLen =
    frc_pkg::LenW'(frc_pkg::FragBytesDefault);
  localparam int unsigned HoldCycles  = 64;
  localparam int unsigned CycleLimit  = 400000;

  // One receive completion as the sender sees it
  typedef struct {
    logic                         active;
    logic                         comp_ok;
    logic [frc_pkg::ByteLenW-1:0] xfer_bytes;
    logic                         sum_ok;
    logic [frc_pkg::SeqW-1:0]     seq_no;
    logic [frc_pkg::LenW-1:0]     length;
    logic [frc_pkg::PortW-1:0]    src_port;
    logic [frc_pkg::PortW-1:0]    dst_port;
    logic [frc_pkg::FlagW-1:0]    flags;
    logic [frc_pkg::SeqW-1:0]     ack_seq;
    logic [frc_pkg::CreditW-1:0]  credit;
  } completion_t;

  logic                         clk_i;
  logic                         rst_ni;

  logic                         in_valid;
  logic                         in_stall;
  logic                         conn_active;
  logic                         completion_ok;
  logic [frc_pkg::ByteLenW-1:0] xfer_bytes;
  logic                         checksum_ok;
  logic [frc_pkg::SeqW-1:0]     hdr_sequence;
  logic [frc_pkg::LenW-1:0]     hdr_length;
  logic [frc_pkg::PortW-1:0]    hdr_src_port;
  logic [frc_pkg::PortW-1:0]    hdr_dst_port;
  logic [frc_pkg::FlagW-1:0]    hdr_flag_bits;
  logic [frc_pkg::SeqW-1:0]     hdr_ack_seq;
  logic [frc_pkg::CreditW-1:0]  hdr_credit;

  logic                         out_valid;
  logic                         out_stall;
  logic [frc_pkg::OutcomeW-1:0] outcome;
  logic                         drop_connection;
  logic                         peer_ack_valid;
  logic [frc_pkg::SeqW-1:0]     peer_ack;
  logic [frc_pkg::CreditW-1:0]  credit_add;
  logic                         next_ack_valid;
  logic [frc_pkg::SeqW-1:0]     next_ack;
  logic                         ack_urgent;

  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [frc_pkg::CfgAddrW-1:0] paddr;
  logic [frc_pkg::CfgDataW-1:0] pwdata;
  logic [frc_pkg::CfgDataW-1:0] prdata;
  logic                         pready;

  // Reassembly state mirrored from the block, plus its two registers
  logic                         rx_assembling;
  logic [frc_pkg::SeqW-1:0]     rx_seq;
  logic [frc_pkg::LenW-1:0]     rx_len;
  logic [frc_pkg::PortW-1:0]    rx_src_port;
  logic [frc_pkg::PortW-1:0]    rx_dst_port;
  logic [frc_pkg::FlagW-1:0]    rx_flags;
  logic [frc_pkg::LenW-1:0]     rx_remaining;
  logic [frc_pkg::FlagW-1:0]    cfg_cong_flags;
  logic [frc_pkg::FlagW-1:0]    cfg_ack_mask;

  frc_pkg::result_t    pending_results[$];
  int unsigned         outcome_hits[9];
  int unsigned         requests_sent;
  int unsigned         settings_used;
  int unsigned         failures;
  int unsigned         cycle_count;
  bit                  idle_on;
  bit                  hold_request;

  fragment_reassembly_checker i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .conn_active_i     (conn_active),
    .completion_ok_i   (completion_ok),
    .xfer_bytes_i      (xfer_bytes),
    .checksum_ok_i     (checksum_ok),
    .hdr_sequence_i    (hdr_sequence),
    .hdr_length_i      (hdr_length),
    .hdr_src_port_i    (hdr_src_port),
    .hdr_dst_port_i    (hdr_dst_port),
    .hdr_flag_bits_i   (hdr_flag_bits),
    .hdr_ack_seq_i     (hdr_ack_seq),
    .hdr_credit_i      (hdr_credit),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .outcome_o         (outcome),
    .drop_connection_o (drop_connection),
    .peer_ack_valid_o  (peer_ack_valid),
    .peer_ack_o        (peer_ack),
    .credit_add_o      (credit_add),
    .next_ack_valid_o  (next_ack_valid),
    .next_ack_o        (next_ack),
    .ack_urgent_o      (ack_urgent),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Any drop forgets the message in progress but keeps the held header.
  function automatic void abandon_message();
    rx_assembling = 1'b0;
    rx_remaining  = '0;
  endfunction

  // Work out the result of one accepted request and advance the mirrored state.
  function automatic frc_pkg::result_t predict_outcome(input completion_t c);
    frc_pkg::result_t r;
    bit               in_step;
    r       = '0;
    in_step = 1'b1;
    if (!c.active) begin
      r.outcome = frc_pkg::OC_INACTIVE;
    end else if (!c.comp_ok) begin
      r.outcome         = frc_pkg::OC_ERROR;
      r.drop_connection = 1'b1;
      abandon_message();
    end else if (c.xfer_bytes < HdrLen) begin
      r.outcome         = frc_pkg::OC_SHORT;
      r.drop_connection = 1'b1;
      abandon_message();
    end else if (!c.sum_ok) begin
      r.outcome         = frc_pkg::OC_BADSUM;
      r.drop_connection = 1'b1;
      abandon_message();
    end else begin
      // A good header always reports its ack and credit, even on mismatch.
      r.peer_ack_valid = 1'b1;
      r.peer_ack       = c.ack_seq;
      r.credit_add     = c.credit;
      if (c.src_port == '0 && c.dst_port == '0 && c.xfer_bytes == HdrLen) begin
        r.outcome = frc_pkg::OC_ACKONLY;
      end else begin
        if (!rx_assembling) begin
          // First fragment: latch the header, flags included.
          rx_assembling = 1'b1;
          rx_seq        = c.seq_no;
          rx_len        = c.length;
          rx_src_port   = c.src_port;
          rx_dst_port   = c.dst_port;
          rx_flags      = c.flags;
          rx_remaining  = c.length;
        end else if (rx_seq != c.seq_no || rx_len != c.length ||
                     rx_src_port != c.src_port || rx_dst_port != c.dst_port) begin
          in_step           = 1'b0;
          r.outcome         = frc_pkg::OC_MISMATCH;
          r.drop_connection = 1'b1;
          abandon_message();
        end
        if (in_step) begin
          if (rx_remaining > FragLen) begin
            rx_remaining = rx_remaining - FragLen;
            r.outcome    = frc_pkg::OC_FRAG;
          end else begin
            abandon_message();
            if (rx_flags == cfg_cong_flags) begin
              r.outcome = frc_pkg::OC_CONGMAP;
            end else begin
              r.outcome        = frc_pkg::OC_DONE;
              r.next_ack_valid = 1'b1;
              r.next_ack       = rx_seq;
            end
            r.ack_urgent = |(rx_flags & cfg_ack_mask);
          end
        end
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request builders
  // ---------------------------------------------------------------------------

  // Good data fragment with random header content.
  function automatic completion_t data_header();
    completion_t c;
    c.active     = 1'b1;
    c.comp_ok    = 1'b1;
    c.sum_ok     = 1'b1;
    c.xfer_bytes = frc_pkg::ByteLenW'($urandom_range(HdrSize + 1, MaxByteLen));
    c.seq_no     = {$urandom, $urandom};
    c.length     = $urandom;
    c.src_port   = frc_pkg::PortW'($urandom);
    c.dst_port   = frc_pkg::PortW'($urandom);
    c.flags      = frc_pkg::FlagW'($urandom);
    c.ack_seq    = {$urandom, $urandom};
    c.credit     = frc_pkg::CreditW'($urandom);
    return c;
  endfunction

  function automatic completion_t ack_only_item();
    completion_t c;
    c            = data_header();
    c.src_port   = '0;
    c.dst_port   = '0;
    c.xfer_bytes = HdrLen;
    return c;
  endfunction

  // One of the three early drops: failed completion, runt, bad checksum.
  function automatic completion_t drop_item();
    completion_t c;
    c = data_header();
    case ($urandom_range(0, 2))
      0:       c.comp_ok    = 1'b0;
      1:       c.xfer_bytes = frc_pkg::ByteLenW'($urandom_range(0, HdrSize - 1));
      default: c.sum_ok     = 1'b0;
    endcase
    return c;
  endfunction

  // Anything the fields allow, byte lengths above range included.
  function automatic completion_t random_completion();
    completion_t c;
    c            = data_header();
    c.active     = ($urandom_range(0, 5) != 0);
    c.comp_ok    = ($urandom_range(0, 5) != 0);
    c.sum_ok     = ($urandom_range(0, 5) != 0);
    c.xfer_bytes = frc_pkg::ByteLenW'($urandom_range(0, 8191));
    if ($urandom_range(0, 1) == 0) begin
      c.src_port = '0;
      c.dst_port = '0;
    end
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Request channel
  // ---------------------------------------------------------------------------

  // Offer one request and hold it until the block takes it. Valid is left high
  // so that a following request goes out back to back.
  task automatic send_request(input completion_t c);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid      <= 1'b1;
    conn_active   <= c.active;
    completion_ok <= c.comp_ok;
    xfer_bytes    <= c.xfer_bytes;
    checksum_ok   <= c.sum_ok;
    hdr_sequence  <= c.seq_no;
    hdr_length    <= c.length;
    hdr_src_port  <= c.src_port;
    hdr_dst_port  <= c.dst_port;
    hdr_flag_bits <= c.flags;
    hdr_ack_seq   <= c.ack_seq;
    hdr_credit    <= c.credit;
    do @(posedge clk_i); while (in_stall);
    pending_results.push_back(predict_outcome(c));
    requests_sent++;
  endtask

  // Send one message fragment by fragment. With breaks allowed, some messages
  // are cut short by a header mismatch or a drop.
  task automatic send_message(input bit allow_breaks);
    completion_t head;
    completion_t frag;
    completion_t side;
    int unsigned frag_count;
    int unsigned break_at;
    bit          truncated;
    head = data_header();
    case ($urandom_range(0, 9))
      0:       head.length = '0;
      1:       head.length = frc_pkg::LenW'(FragSize * $urandom_range(1, 4));
      2:       head.length = frc_pkg::LenW'(FragSize * $urandom_range(1, 4) + 1);
      3:       head.length = $urandom;
      default: head.length = frc_pkg::LenW'($urandom_range(1, 4 * FragSize));
    endcase
    case ($urandom_range(0, 3))
      0:       head.flags = cfg_cong_flags;
      1:       head.flags = head.flags & ~cfg_ack_mask;
      default: ;
    endcase
    frag_count = (head.length == '0) ? 1 :
                 int'((64'(head.length) + FragSize - 1) / FragSize);
    // Huge messages: send a few fragments, then clear with a drop.
    truncated = (frag_count > 6);
    if (truncated) frag_count = $urandom_range(1, 4);
    break_at = (allow_breaks && $urandom_range(0, 4) == 0) ?
               $urandom_range(0, frag_count - 1) : frag_count;
    for (int unsigned k = 0; k < frag_count; k++) begin
      frag            = head;
      frag.xfer_bytes = frc_pkg::ByteLenW'($urandom_range(HdrSize, MaxByteLen));
      frag.ack_seq    = {$urandom, $urandom};
      frag.credit     = frc_pkg::CreditW'($urandom);
      // Later fragments may carry other flags; the block must ignore them.
      if (k > 0 && $urandom_range(0, 3) == 0) frag.flags = frc_pkg::FlagW'($urandom);
      // Slip in an ACK-only or an inactive request mid-message.
      if ($urandom_range(0, 7) == 0) begin
        side = ack_only_item();
        if ($urandom_range(0, 1) == 0) side.active = 1'b0;
        send_request(side);
      end
      if (k == break_at) begin
        if ($urandom_range(0, 1) == 0) begin
          case ($urandom_range(0, 3))
            0:       frag.seq_no   ^= 64'd1 << $urandom_range(0, 63);
            1:       frag.length   ^= 32'd1 << $urandom_range(0, 31);
            2:       frag.src_port ^= 16'd1 << $urandom_range(0, 15);
            default: frag.dst_port ^= 16'd1 << $urandom_range(0, 15);
          endcase
        end else begin
          frag = drop_item();
        end
        send_request(frag);
        return;
      end
      send_request(frag);
    end
    if (truncated) send_request(drop_item());
  endtask

  // Drop valid and wait until every expected result has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------

  task automatic apb_write(input logic [frc_pkg::CfgAddrW-1:0] addr,
                           input logic [frc_pkg::FlagW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= frc_pkg::CfgDataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apb_read(input logic [frc_pkg::CfgAddrW-1:0] addr,
                          output logic [frc_pkg::CfgDataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    data     = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Write both registers while the block is idle, then read them back.
  task automatic set_config(input logic [frc_pkg::FlagW-1:0] cong,
                            input logic [frc_pkg::FlagW-1:0] mask);
    logic [frc_pkg::CfgDataW-1:0] readback;
    drain_results();
    apb_write({frc_pkg::RegCongFlag, 2'b00}, cong);
    apb_write({frc_pkg::RegAckMask, 2'b00}, mask);
    cfg_cong_flags = cong;
    cfg_ack_mask   = mask;
    apb_read({frc_pkg::RegCongFlag, 2'b00}, readback);
    check_field("cong_flag_value readback", 64'(cong), 64'(readback[frc_pkg::FlagW-1:0]));
    apb_read({frc_pkg::RegAckMask, 2'b00}, readback);
    check_field("ack mask readback", 64'(mask), 64'(readback[frc_pkg::FlagW-1:0]));
    settings_used++;
  endtask

  // ---------------------------------------------------------------------------
  // Result channel
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endtask

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    frc_pkg::result_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("outcome: expected no result, got %0d", outcome);
        failures++;
      end else begin
        want = pending_results.pop_front();
        check_field("outcome", 64'(want.outcome), 64'(outcome));
        check_field("drop_connection", 64'(want.drop_connection), 64'(drop_connection));
        check_field("peer_ack_valid", 64'(want.peer_ack_valid), 64'(peer_ack_valid));
        check_field("peer_ack", want.peer_ack, peer_ack);
        check_field("credit_add", 64'(want.credit_add), 64'(credit_add));
        check_field("next_ack_valid", 64'(want.next_ack_valid), 64'(next_ack_valid));
        check_field("next_ack", want.next_ack, next_ack);
        check_field("ack_urgent", 64'(want.ack_urgent), 64'(ack_urgent));
        if (outcome <= frc_pkg::OC_MISMATCH) outcome_hits[outcome]++;
      end
    end
  end

  // Receiver stalls: a long hold-off when asked for, else short random bursts.
  initial begin : stall_gen
    int unsigned held;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        out_stall <= 1'b1;
        for (held = 0; held < HoldCycles; held++) @(posedge clk_i);
        hold_request = 1'b0;
        out_stall   <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("fragment_reassembly_checker verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Each early check, ACK-only, single and multi-fragment messages, congestion
  // maps, a mismatch, a mid-message drop and extreme field values.
  task automatic test_directed_cases();
    completion_t c;
    completion_t gap;
    c = data_header(); c.active = 1'b0;          send_request(c);
    c = data_header(); c.comp_ok = 1'b0;         send_request(c);
    c = data_header(); c.xfer_bytes = '0;        send_request(c);
    c = data_header(); c.xfer_bytes = frc_pkg::ByteLenW'(HdrSize - 1);
    send_request(c);
    c = data_header(); c.sum_ok = 1'b0;          send_request(c);
    c = ack_only_item();
    c.seq_no = '1; c.length = '1; c.flags = '1; c.ack_seq = '1; c.credit = '1;
    send_request(c);
    // Zero-length message completes at once and asks for an ack.
    c = data_header(); c.length = '0; c.flags = cfg_ack_mask; send_request(c);
    // Exactly one full fragment.
    c = data_header(); c.length = FragLen; c.flags = '0; send_request(c);
    // Two fragments with an ACK-only and an inactive request in between;
    // the flags of the second fragment must be ignored.
    c = data_header(); c.length = FragLen + 1; c.flags = cfg_ack_mask;
    c.src_port = '1;
    send_request(c);
    gap = ack_only_item();                       send_request(gap);
    gap = data_header(); gap.active = 1'b0;      send_request(gap);
    c.flags = ~c.flags; c.xfer_bytes = HdrLen;   send_request(c);
    // Congestion maps, one and two fragments.
    c = data_header(); c.length = 1; c.flags = cfg_cong_flags; send_request(c);
    c = data_header(); c.length = 2 * FragLen; c.flags = cfg_cong_flags;
    send_request(c);
    send_request(c);
    // Header mismatch on the destination port.
    c = data_header(); c.length = 3 * FragLen;   send_request(c);
    c.dst_port ^= 16'd1;                         send_request(c);
    // Drop mid-message, then a fresh message must start cleanly.
    c = data_header(); c.length = 3 * FragLen;   send_request(c);
    gap = data_header(); gap.comp_ok = 1'b0;     send_request(gap);
    c = data_header(); c.length = FragLen - 1;   send_request(c);
    // Byte length above range and all-ones fields.
    c = data_header();
    c.xfer_bytes = '1; c.seq_no = '1; c.length = '0; c.src_port = '1; c.dst_port = '1;
    c.flags = '1; c.ack_seq = '1; c.credit = '1;
    send_request(c);
    // Maximum byte length starting a huge message, cleared by a bad checksum.
    c = data_header(); c.xfer_bytes = frc_pkg::ByteLenW'(MaxByteLen); c.length = '1;
    send_request(c);
    gap = data_header(); gap.sum_ok = 1'b0;      send_request(gap);
  endtask

  // Hold the result side off for a long stretch while requests keep coming, so
  // the block fills up and stalls its input.
  task automatic test_backpressure();
    int unsigned stop_at;
    stop_at      = requests_sent + 24;
    idle_on      = 1'b0;
    hold_request = 1'b1;
    while (requests_sent < stop_at) send_message(1'b0);
    idle_on = 1'b1;
  endtask

  // Mostly well-formed messages with random content, the rest noise.
  task automatic run_traffic(input int unsigned count, input bit allow_idle);
    int unsigned stop_at;
    int unsigned pick;
    stop_at = requests_sent + count;
    idle_on = allow_idle;
    while (requests_sent < stop_at) begin
      if (allow_idle && $urandom_range(0, 15) == 0) idle_on = ($urandom_range(0, 2) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        send_message(1'b1);
      end else if (pick < 78) begin
        send_request(ack_only_item());
      end else if (pick < 88) begin
        send_request(drop_item());
      end else begin
        send_request(random_completion());
      end
    end
  endtask

  // Traffic under register extremes and a random setting.
  task automatic test_config_sweep();
    set_config(8'h00, 8'hFF);
    run_traffic(260, 1'b1);
    set_config(8'hFF, 8'h00);
    run_traffic(260, 1'b1);
    set_config(frc_pkg::FlagW'($urandom), frc_pkg::FlagW'($urandom));
    run_traffic(260, 1'b1);
  endtask

  // Final stretch at full rate: no gaps, no stalls.
  task automatic test_streaming();
    set_config(frc_pkg::CongFlagReset, frc_pkg::AckMaskReset | frc_pkg::FlagW'($urandom));
    run_traffic(300, 1'b0);
  endtask

  initial begin : main_sequence
    rst_ni         <= 1'b0;
    in_valid       <= 1'b0;
    conn_active    <= 1'b0;
    completion_ok  <= 1'b0;
    xfer_bytes     <= '0;
    checksum_ok    <= 1'b0;
    hdr_sequence   <= '0;
    hdr_length     <= '0;
    hdr_src_port   <= '0;
    hdr_dst_port   <= '0;
    hdr_flag_bits  <= '0;
    hdr_ack_seq    <= '0;
    hdr_credit     <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    idle_on         = 1'b1;
    hold_request    = 1'b0;
    cfg_cong_flags  = frc_pkg::CongFlagReset;
    cfg_ack_mask    = frc_pkg::AckMaskReset;
    rx_assembling   = 1'b0;
    rx_seq          = '0;
    rx_len          = '0;
    rx_src_port     = '0;
    rx_dst_port     = '0;
    rx_flags        = '0;
    rx_remaining    = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_backpressure();
    test_config_sweep();
    test_streaming();
    drain_results();

    $display("Checked %0d requests over %0d register settings plus reset values.",
             requests_sent, settings_used);
    $display("Outcomes: inactive %0d error %0d short %0d badsum %0d ackonly %0d frag %0d %s",
             outcome_hits[frc_pkg::OC_INACTIVE], outcome_hits[frc_pkg::OC_ERROR],
             outcome_hits[frc_pkg::OC_SHORT], outcome_hits[frc_pkg::OC_BADSUM],
             outcome_hits[frc_pkg::OC_ACKONLY], outcome_hits[frc_pkg::OC_FRAG],
             $sformatf("done %0d congmap %0d mismatch %0d",
                       outcome_hits[frc_pkg::OC_DONE],
                       outcome_hits[frc_pkg::OC_CONGMAP],
                       outcome_hits[frc_pkg::OC_MISMATCH]));
    if (failures == 0) begin
      $display("fragment_reassembly_checker verification clean");
    end else begin
      $display("fragment_reassembly_checker verification failed");
    end
    $finish;
  end

endmodule

// File: fragment_reassembly_checker.f
hw/rtl/frc_pkg.sv
hw/rtl/frc_front.sv
hw/rtl/frc_queue.sv
hw/rtl/frc_back.sv
hw/rtl/fragment_reassembly_checker.sv
hw/rtl/frc_checker.sv
verif/tb_fragment_reassembly_checker.sv
